// ----- sv/assert_macros.svh -----
// assertion macros used by fdmc_change_count
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// clocked check, switched off while reset is low
`define FDMC_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// clocked check that also holds during reset
`define FDMC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FDMC_ASSERT(lbl, clk, rst_n, prop, msg)
`define FDMC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ----- sv/fdmc_pkg.sv -----
`default_nettype none

package fdmc_pkg;

	// frame store geometry
	localparam int unsigned MAX_FRAME_PIXELS = 262144;
	localparam int unsigned ADDR_W = $clog2(MAX_FRAME_PIXELS);
	localparam int unsigned POS_W = $clog2(MAX_FRAME_PIXELS + 1);

	// change counter
	localparam int unsigned COUNT_W = 19;
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	// threshold register reset value
	localparam logic [7:0] THRESHOLD_RESET = 8'd25;

	// fixed-point bgr to gray weights, 14 fraction bits
	localparam int unsigned GRAY_FRAC_W = 14;
	localparam int unsigned GRAY_SUM_W = 8 + GRAY_FRAC_W;
	localparam logic [GRAY_FRAC_W-1:0] GRAY_COEF_B = 14'd1868;
	localparam logic [GRAY_FRAC_W-1:0] GRAY_COEF_G = 14'd9617;
	localparam logic [GRAY_FRAC_W-1:0] GRAY_COEF_R = 14'd4899;
	localparam logic [GRAY_SUM_W-1:0] GRAY_ROUND = GRAY_SUM_W'(1) << (GRAY_FRAC_W - 1);

	// one pixel as kept in the frame store: blue in the low byte
	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pixel_t;

	// per-item control carried down the pipeline
	typedef struct packed {
		logic cmp_en;
		logic emit;
		logic last;
	} item_ctl_t;

endpackage

`default_nettype wire

// ----- sv/fdmc_frame_store.sv -----
`default_nettype none

module fdmc_frame_store (
	input  wire logic                       clk,
	input  wire logic                       en,
	input  wire logic [fdmc_pkg::ADDR_W-1:0] addr,
	input  wire fdmc_pkg::pixel_t           wdata,
	output fdmc_pkg::pixel_t                rdata
);
	import fdmc_pkg::*;

	pixel_t mem [MAX_FRAME_PIXELS];
	pixel_t rdata_q;

	// read-first single port: old pixel out, new pixel in, same address
	always_ff @(posedge clk) begin
		if (en) begin
			rdata_q   <= mem[addr];
			mem[addr] <= wdata;
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ----- sv/fdmc_gray_diff.sv -----
`default_nettype none

module fdmc_gray_diff (
	input  wire fdmc_pkg::pixel_t cur,
	input  wire fdmc_pkg::pixel_t prev,
	output logic [7:0]            gray
);
	import fdmc_pkg::*;

	logic [7:0]            d_b;
	logic [7:0]            d_g;
	logic [7:0]            d_r;
	logic [GRAY_SUM_W-1:0] sum;

	function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
		abs_diff = (a > b) ? (a - b) : (b - a);
	endfunction

	// per-channel absolute difference
	assign d_b = abs_diff(cur.blue, prev.blue);
	assign d_g = abs_diff(cur.green, prev.green);
	assign d_r = abs_diff(cur.red, prev.red);

	// weighted sum with rounding, then drop the fraction bits
	assign sum = GRAY_SUM_W'(d_b) * GRAY_SUM_W'(GRAY_COEF_B)
		+ GRAY_SUM_W'(d_g) * GRAY_SUM_W'(GRAY_COEF_G)
		+ GRAY_SUM_W'(d_r) * GRAY_SUM_W'(GRAY_COEF_R)
		+ GRAY_ROUND;

	assign gray = sum[GRAY_SUM_W-1:GRAY_FRAC_W];

endmodule

`default_nettype wire

// ----- sv/fdmc_change_count.sv -----
`default_nettype none
`include "assert_macros.svh"

module fdmc_change_count (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        s1_valid,
	input  wire fdmc_pkg::item_ctl_t         s1_ctl,
	input  wire logic [7:0]                  s1_gray,
	input  wire logic [7:0]                  threshold,
	output logic                             s1_ready,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic [fdmc_pkg::COUNT_W-1:0]     changed_pixels
);
	import fdmc_pkg::*;

	logic               valid_s2;
	item_ctl_t          ctl_s2;
	logic [7:0]         gray_s2;
	logic [COUNT_W-1:0] running_q;
	logic [COUNT_W-1:0] count_q;
	logic               out_valid_q;
	logic               s2_go;
	logic               s2_free;
	logic               inc;
	logic [COUNT_W-1:0] next_count;

	// an emitting item waits only while the output register is full and stalled
	assign s2_go   = valid_s2 && (!ctl_s2.emit || !out_valid_q || out_ready);
	assign s2_free = !valid_s2 || s2_go;
	assign s1_ready = s2_free;

	// saturating increment for a changed pixel
	assign inc = ctl_s2.cmp_en && (gray_s2 > threshold) && (running_q < COUNT_MAX);
	assign next_count = running_q + COUNT_W'(inc);

	// gray value stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= s1_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_free && s1_valid) begin
			ctl_s2  <= s1_ctl;
			gray_s2 <= s1_gray;
		end
	end

	// running count, cleared at each frame end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= '0;
		end else if (s2_go) begin
			if (ctl_s2.last) begin
				running_q <= '0;
			end else begin
				running_q <= next_count;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s2_go && ctl_s2.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_go && ctl_s2.emit) begin
			count_q <= next_count;
		end
	end

	assign out_valid      = out_valid_q;
	assign changed_pixels = count_q;

	`FDMC_ASSERT(a_emit_loads_out, clk, arst_n, s2_go && ctl_s2.emit |=> out_valid_q, "count lost")
	`FDMC_ASSERT(a_frame_end_clears, clk, arst_n, s2_go && ctl_s2.last |=> running_q == '0, "no clear")
	`FDMC_ASSERT(a_stall_holds_s2, clk, arst_n, valid_s2 && !s2_go |=> valid_s2, "stalled item lost")
	`FDMC_ASSERT_ALWAYS(a_reset_no_out, clk, !arst_n |=> !out_valid_q, "output valid in reset")

endmodule

`default_nettype wire

// ----- sv/frame_difference_motion_counter.sv -----
// Frame-difference motion counter.
// Input channel (in_valid/in_ready): one BGR pixel per item in raster order,
// frame_end high on the last pixel of each frame. Output channel
// (out_valid/out_ready): one changed_pixels item per frame end, except the
// first frame, which only fills the frame store.
// Configuration channel (cfg_valid/cfg_ready): writes diff_threshold (reset 25),
// always ready; write it only while the block is idle.
// Throughput: one pixel per cycle while in_ready is high, set by the single-port
// frame store doing one read and one write per pixel at the same address.
// Path: the count for a frame shows on out_valid once the frame_end pixel has
// passed the store read stage, the gray stage and the output register.
// Reset: position, frame flag, count and valids clear; the frame store is not
// cleared, there is no clearing pass, the block is ready right after reset.
// Stall: only a counted frame-end item waits behind a full, stalled output register;
// other pixels keep flowing, and in_ready drops once that item holds the pipe.
`default_nettype none

module frame_difference_motion_counter (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic [7:0]                  diff_threshold,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [7:0]                  pixel_blue,
	input  wire logic [7:0]                  pixel_green,
	input  wire logic [7:0]                  pixel_red,
	input  wire logic                        frame_end,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic [fdmc_pkg::COUNT_W-1:0]     changed_pixels
);
	import fdmc_pkg::*;

	logic [7:0]       threshold_q;
	logic [POS_W-1:0] pos_q;
	logic             have_prev_q;
	logic             valid_s1;
	item_ctl_t        ctl_s1;
	pixel_t           pix_s1;
	pixel_t           pix_in;
	pixel_t           prev_pix;
	logic             in_acc;
	logic             in_range;
	logic             s1_free;
	logic             s1_ready;
	logic [7:0]       gray_s1;

	// threshold register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESHOLD_RESET;
		end else if (cfg_valid) begin
			threshold_q <= diff_threshold;
		end
	end

	// input handshake
	assign s1_free  = !valid_s1 || s1_ready;
	assign in_ready = s1_free;
	assign in_acc   = in_valid && s1_free;
	assign in_range = pos_q < POS_W'(MAX_FRAME_PIXELS);
	assign pix_in   = '{red: pixel_red, green: pixel_green, blue: pixel_blue};

	// frame position and first-frame flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			have_prev_q <= 1'b0;
		end else if (in_acc) begin
			if (frame_end) begin
				pos_q       <= '0;
				have_prev_q <= 1'b1;
			end else if (in_range) begin
				pos_q <= pos_q + POS_W'(1);
			end
		end
	end

	// frame store: stored pixel comes out as the new one goes in
	fdmc_frame_store u_store (
		.clk   (clk),
		.en    (in_acc && in_range),
		.addr  (pos_q[ADDR_W-1:0]),
		.wdata (pix_in),
		.rdata (prev_pix)
	);

	// store read stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_free) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			pix_s1        <= pix_in;
			ctl_s1.cmp_en <= have_prev_q && in_range;
			ctl_s1.emit   <= have_prev_q && frame_end;
			ctl_s1.last   <= frame_end;
		end
	end

	// gray of the per-channel difference
	fdmc_gray_diff u_gray (
		.cur  (pix_s1),
		.prev (prev_pix),
		.gray (gray_s1)
	);

	// threshold compare, count and output register
	fdmc_change_count u_count (
		.clk            (clk),
		.arst_n         (arst_n),
		.s1_valid       (valid_s1),
		.s1_ctl         (ctl_s1),
		.s1_gray        (gray_s1),
		.threshold      (threshold_q),
		.s1_ready       (s1_ready),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.changed_pixels (changed_pixels)
	);

endmodule

`default_nettype wire
